>>> rtl/core/iir_biquad_cascade_assert.svh
// Assertion macros shared by the biquad cascade RTL.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef IIR_BIQUAD_CASCADE_ASSERT_SVH
`define IIR_BIQUAD_CASCADE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define IBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iir_biquad_cascade: same-cycle check failed");
`define IBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iir_biquad_cascade: next-cycle check failed");
`else
`define IBC_ASSERT_SAME(label, ante, cons)
`define IBC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/iir_bq_pkg.sv
package iir_bq_pkg;

    localparam int COEF_W = 18;
    localparam int DLY_W  = 32;
    localparam int SMP_W  = 16;
    localparam int REG_W  = 54;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic [REG_W-1:0] B0_RESET = 54'd2251808403652608;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coef;

    // word handed from one section to the next
    typedef struct packed {
        logic                    vld;
        logic signed [DLY_W-1:0] x;
        logic                    clip;
    } t_link;

endpackage

>>> rtl/core/iir_bq_cell.sv
`include "iir_biquad_cascade_assert.svh"

// One DF-II biquad section with a single shared 18x32 multiplier.
module iir_bq_cell
    import iir_bq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_coef i_coef,
    input  t_link i_link,
    output t_link o_link
);

    localparam int PROD_W = COEF_W + DLY_W;
    localparam int ACC_W  = 52;
    localparam int RND_W  = ACC_W - 15;

    typedef enum logic [2:0] {
        ST_IDLE, ST_A2, ST_B1, ST_W0, ST_B0, ST_ACC, ST_Y
    } t_state;

    t_state                    r_state;
    logic signed [DLY_W-1:0]   r_w1;
    logic signed [DLY_W-1:0]   r_w2;
    logic signed [DLY_W-1:0]   r_w0;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_clip;
    t_link                     r_out;

    logic signed [COEF_W-1:0]  w_mc;
    logic signed [DLY_W-1:0]   w_md;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [ACC_W-1:0]   w_rnd_sum;
    logic signed [RND_W-1:0]   w_rnd;
    logic                      w_sat;
    logic signed [DLY_W-1:0]   w_satv;

    always_comb begin
        case (r_state)
            ST_IDLE: begin w_mc = i_coef.a1; w_md = r_w1; end
            ST_A2:   begin w_mc = i_coef.a2; w_md = r_w2; end
            ST_B1:   begin w_mc = i_coef.b1; w_md = r_w1; end
            ST_W0:   begin w_mc = i_coef.b2; w_md = r_w2; end
            ST_B0:   begin w_mc = i_coef.b0; w_md = r_w0; end
            default: begin w_mc = '0;        w_md = '0;   end
        endcase
    end

    assign w_prod     = w_mc * w_md;
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // round half up to Q8.23, then clamp to 32 bits
    assign w_rnd_sum = r_acc + ACC_W'(1 <<< 14);
    assign w_rnd     = w_rnd_sum[ACC_W-1:15];
    assign w_sat     = !((&w_rnd[RND_W-1:DLY_W-1]) || !(|w_rnd[RND_W-1:DLY_W-1]));
    assign w_satv    = !w_sat ? w_rnd[DLY_W-1:0]
                     : (w_rnd[RND_W-1] ? {1'b1, {(DLY_W-1){1'b0}}}
                                       : {1'b0, {(DLY_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_w1      <= '0;
            r_w2      <= '0;
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_link.vld) begin
                        r_acc   <= {{(ACC_W-DLY_W-15){i_link.x[DLY_W-1]}}, i_link.x, 15'b0};
                        r_prod  <= w_prod;
                        r_clip  <= i_link.clip;
                        r_state <= ST_A2;
                    end
                end
                ST_A2: begin
                    r_acc   <= r_acc - w_prod_ext;
                    r_prod  <= w_prod;
                    r_state <= ST_B1;
                end
                ST_B1: begin
                    r_acc   <= r_acc - w_prod_ext;
                    r_prod  <= w_prod;
                    r_state <= ST_W0;
                end
                ST_W0: begin
                    r_w0    <= w_satv;
                    r_clip  <= r_clip | w_sat;
                    r_acc   <= w_prod_ext;
                    r_prod  <= w_prod;
                    r_state <= ST_B0;
                end
                ST_B0: begin
                    r_acc   <= r_acc + w_prod_ext;
                    r_prod  <= w_prod;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc   <= r_acc + w_prod_ext;
                    r_state <= ST_Y;
                end
                ST_Y: begin
                    r_out.vld  <= 1'b1;
                    r_out.x    <= w_satv;
                    r_out.clip <= r_clip | w_sat;
                    r_w2       <= r_w1;
                    r_w1       <= r_w0;
                    r_state    <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_link = r_out;

    `IBC_ASSERT_SAME(a_no_overrun, i_link.vld, r_state == ST_IDLE)
    `IBC_ASSERT_NEXT(a_out_pulse, r_out.vld, !r_out.vld)
    `IBC_ASSERT_NEXT(a_dly_hold, r_state != ST_Y, $stable(r_w1) && $stable(r_w2))

endmodule

>>> rtl/core/iir_biquad_cascade.sv
// An accepted sample is registered into section 0 and runs through the sections in turn.
// A new sample is taken only with none in flight and no result waiting in the skid slot;
//   each section's single 18x32 multiplier runs five products in turn.
// Reset (synchronous, i_rst_n low): delay words cleared, b0 = unity, others zero,
//   output and in-flight control cleared.
`include "iir_biquad_cascade_assert.svh"

module iir_biquad_cascade
    import iir_bq_pkg::*;
#(
    parameter int SECTIONS = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input sample channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SMP_W-1:0] i_sample_in,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SMP_W-1:0] o_sample_out,
    output logic                    o_clipped,
    // coefficient write port
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [REG_W-1:0]        i_cfg_data
);

    localparam int FIN_W = DLY_W + 1;
    localparam int Q_W   = FIN_W - 8;

    // coefficient registers, section s in bits 18*s +: 18
    logic [REG_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    t_link w_link [SECTIONS+1];
    t_link r_in_link;

    logic                    r_busy;
    logic                    r_out_vld;
    logic signed [SMP_W-1:0] r_out_smp;
    logic                    r_out_clip;
    logic                    r_pend_vld;     // skid slot when output is still held
    logic signed [SMP_W-1:0] r_pend_smp;
    logic                    r_pend_clip;

    logic                    w_accept;
    logic                    w_take;
    logic                    w_done;
    logic signed [FIN_W-1:0] w_fin_sum;
    logic signed [Q_W-1:0]   w_q;
    logic                    w_q_sat;
    logic signed [SMP_W-1:0] w_fin_smp;
    logic                    w_fin_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RESET;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:  r_b0 <= i_cfg_data;
                REG_B1:  r_b1 <= i_cfg_data;
                REG_B2:  r_b2 <= i_cfg_data;
                REG_A1:  r_a1 <= i_cfg_data;
                REG_A2:  r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one item in flight; a finished result may sit in the output register
    // while the next sample is taken
    assign o_ready  = !r_busy && !r_pend_vld;
    assign w_accept = i_valid && o_ready;
    assign w_take   = r_out_vld && i_ready;

    // sample enters section 0 as Q8.23
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_link.vld <= 1'b0;
        end else begin
            r_in_link.vld <= w_accept;
        end
        if (w_accept) begin
            r_in_link.x    <= {{(DLY_W-SMP_W-8){i_sample_in[SMP_W-1]}}, i_sample_in, 8'b0};
            r_in_link.clip <= 1'b0;
        end
    end

    assign w_link[0] = r_in_link;

    // chain of sections, each hands its y to the next
    for (genvar s = 0; s < SECTIONS; s++) begin : g_sec
        t_coef w_coef;
        assign w_coef.b0 = r_b0[COEF_W*s +: COEF_W];
        assign w_coef.b1 = r_b1[COEF_W*s +: COEF_W];
        assign w_coef.b2 = r_b2[COEF_W*s +: COEF_W];
        assign w_coef.a1 = r_a1[COEF_W*s +: COEF_W];
        assign w_coef.a2 = r_a2[COEF_W*s +: COEF_W];

        iir_bq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (w_coef),
            .i_link  (w_link[s]),
            .o_link  (w_link[s+1])
        );
    end

    // final Q8.23 -> Q1.15: round half up, clamp to 16 bits
    assign w_done    = w_link[SECTIONS].vld;
    assign w_fin_sum = {w_link[SECTIONS].x[DLY_W-1], w_link[SECTIONS].x} + FIN_W'(128);
    assign w_q       = w_fin_sum[FIN_W-1:8];
    assign w_q_sat   = !((&w_q[Q_W-1:SMP_W-1]) || !(|w_q[Q_W-1:SMP_W-1]));
    assign w_fin_smp = !w_q_sat ? w_q[SMP_W-1:0]
                     : (w_q[Q_W-1] ? {1'b1, {(SMP_W-1){1'b0}}}
                                   : {1'b0, {(SMP_W-1){1'b1}}});
    assign w_fin_clip = w_link[SECTIONS].clip | w_q_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end

            if (w_done) begin
                if (!r_out_vld || w_take) begin
                    r_out_vld  <= 1'b1;
                    r_out_smp  <= w_fin_smp;
                    r_out_clip <= w_fin_clip;
                end else begin
                    r_pend_vld  <= 1'b1;
                    r_pend_smp  <= w_fin_smp;
                    r_pend_clip <= w_fin_clip;
                end
            end else if (w_take) begin
                if (r_pend_vld) begin
                    r_out_smp  <= r_pend_smp;
                    r_out_clip <= r_pend_clip;
                    r_pend_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out_smp;
    assign o_clipped    = r_out_clip;

    `IBC_ASSERT_SAME(a_pend_needs_out, r_pend_vld, r_out_vld)
    `IBC_ASSERT_SAME(a_done_while_busy, w_done, r_busy)
    `IBC_ASSERT_NEXT(a_accept_busy, w_accept, r_busy)

endmodule

>>> bench/tb_iir_biquad_cascade.sv
module tb_iir_biquad_cascade;
    timeunit 1ns;
    timeprecision 1ps;

    import iir_bq_pkg::*;

    localparam int STAGES      = 3;
    localparam int NUM_REGS    = 5;
    // input accept to o_valid
    localparam int LATENCY     = 7 * STAGES + 1;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_PRINTS  = 40;

    localparam logic [COEF_W-1:0]       COEF_MAX = 18'h1FFFF;   // +3.99997 in Q3.15
    localparam logic [COEF_W-1:0]       COEF_MIN = 18'h20000;   // -4.0 in Q3.15
    localparam logic signed [SMP_W-1:0] SMP_MAX  = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN  = 16'sh8000;

    // clamp bounds for Q8.23 delay words and the Q1.15 output
    localparam longint DLY_HI = (longint'(1) <<< (DLY_W - 1)) - 1;
    localparam longint DLY_LO = -(longint'(1) <<< (DLY_W - 1));
    localparam longint SMP_HI = (longint'(1) <<< (SMP_W - 1)) - 1;
    localparam longint SMP_LO = -(longint'(1) <<< (SMP_W - 1));

    // one expected output word
    typedef struct {
        logic signed [SMP_W-1:0] smp;
        logic                    clip;
        int unsigned             seq;
    } t_filt_word;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    o_ready;
    logic signed [SMP_W-1:0] i_sample_in = '0;
    logic                    o_valid;
    logic                    i_ready     = 1'b0;
    logic signed [SMP_W-1:0] o_sample_out;
    logic                    o_clipped;
    logic                    i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]        i_cfg_idx   = '0;
    logic [REG_W-1:0]        i_cfg_data  = '0;

    // ------------------------------------------------------------------
    // Shadow state of the cascade: coefficient registers and delay words
    // ------------------------------------------------------------------
    logic [REG_W-1:0]        coef_word [NUM_REGS];
    logic signed [DLY_W-1:0] dly1 [STAGES];
    logic signed [DLY_W-1:0] dly2 [STAGES];
    logic                    cas_clip;
    t_filt_word              filt_pending [$];

    // bookkeeping
    int unsigned words_in   = 0;
    int unsigned words_out  = 0;
    int unsigned clips_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned err_cnt    = 0;
    int unsigned cyc_cnt    = 0;

    // traffic shaping knobs; "calm" means no idling on that side
    logic        src_calm  = 1'b0;
    logic        sink_calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned calm_left  = 0;
    t_filt_word  due;

    iir_biquad_cascade #(
        .SECTIONS     (STAGES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // signed Q3.15 slot s of a packed coefficient register
    function automatic longint coef_slot(input logic [REG_W-1:0] word, input int s);
        logic signed [COEF_W-1:0] c;
        c = word[s*COEF_W +: COEF_W];
        return longint'(c);
    endfunction

    // round half up: add half an LSB, then arithmetic shift (floor)
    function automatic longint round_down(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // saturate to the Q8.23 range, noting any clamp in cas_clip
    function automatic longint clamp_dly(input longint v);
        if (v > DLY_HI) begin
            cas_clip = 1'b1;
            return DLY_HI;
        end
        if (v < DLY_LO) begin
            cas_clip = 1'b1;
            return DLY_LO;
        end
        return v;
    endfunction

    // Push one sample through all sections, updating the shadow delay words.
    // Products are kept exact at 2^-38 and reduced to Q8.23 per sum.
    function automatic t_filt_word run_cascade(input logic signed [SMP_W-1:0] smp);
        t_filt_word r;
        longint     x, w0, w1, w2, acc, q;
        cas_clip = 1'b0;
        x = longint'(smp) * 256;                     // Q1.15 -> Q8.23
        for (int s = 0; s < STAGES; s++) begin
            w1  = dly1[s];
            w2  = dly2[s];
            // feedback path, a0 fixed at one
            acc = x * 32768
                - coef_slot(coef_word[REG_A1], s) * w1
                - coef_slot(coef_word[REG_A2], s) * w2;
            w0  = clamp_dly(round_down(acc, 15));
            // feed-forward path
            acc = coef_slot(coef_word[REG_B0], s) * w0
                + coef_slot(coef_word[REG_B1], s) * w1
                + coef_slot(coef_word[REG_B2], s) * w2;
            x   = clamp_dly(round_down(acc, 15));
            dly2[s] = w1[DLY_W-1:0];
            dly1[s] = w0[DLY_W-1:0];
        end
        // Q8.23 -> Q1.15 with output saturation
        q = round_down(x, 8);
        if (q > SMP_HI) begin
            q = SMP_HI;
            cas_clip = 1'b1;
        end
        if (q < SMP_LO) begin
            q = SMP_LO;
            cas_clip = 1'b1;
        end
        r.smp  = q[SMP_W-1:0];
        r.clip = cas_clip;
        r.seq  = 0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int rand_pause();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 0;
        if (pick < 85) return $urandom_range(1, 4);
        if (pick < 97) return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        int unsigned pick;
        logic [31:0] r;
        int          v;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        if (pick < 45) return r[SMP_W-1:0];          // full scale
        if (pick < 75) begin                          // low level signal
            v = int'($urandom_range(0, 2000)) - 1000;
            return v[SMP_W-1:0];
        end
        if (pick < 88) return '0;                     // let the filter ring down
        return r[0] ? SMP_MAX : SMP_MIN;
    endfunction

    // b coefficient in about +/-1.0
    function automatic logic [COEF_W-1:0] rand_gain();
        int g;
        g = int'($urandom_range(0, 65536)) - 32768;
        return g[COEF_W-1:0];
    endfunction

    function automatic logic [REG_W-1:0] rand_reg();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[REG_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        if (err_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    // Offer one sample word; returns at the edge where it is taken, with
    // valid still high so a following word can go out back to back.
    task automatic push_sample(input logic signed [SMP_W-1:0] smp);
        int         gap;
        t_filt_word w;
        gap = src_calm ? 0 : rand_pause();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= smp;
        do @(posedge i_clk); while (!o_ready);
        w     = run_cascade(smp);
        w.seq = words_in;
        filt_pending.push_back(w);
        words_in++;
    endtask

    // Drop valid and hold off until every expected output is back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (filt_pending.size() != 0) @(posedge i_clk);
    endtask

    // Register write; only issued with the datapath empty.
    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx < NUM_REGS) coef_word[idx] = val;
        cfg_writes++;
    endtask

    // Same value into every coefficient register.
    task automatic write_all_coefs(input logic [REG_W-1:0] val);
        for (int k = 0; k < NUM_REGS; k++) write_coef(k[IDX_W-1:0], val);
    endtask

    // Random stable biquads: poles inside the unit circle via the
    // stability triangle |a2| < 1, |a1| < 1 + a2, both with margin.
    task automatic load_stable_filter();
        logic [REG_W-1:0] rb0, rb1, rb2, ra1, ra2;
        int               a1, a2, lim;
        for (int s = 0; s < STAGES; s++) begin
            a2  = int'($urandom_range(0, 58982)) - 29491;
            lim = ((32768 + a2) * 29) / 32;
            a1  = int'($urandom_range(0, 2 * lim)) - lim;
            rb0[s*COEF_W +: COEF_W] = rand_gain();
            rb1[s*COEF_W +: COEF_W] = rand_gain();
            rb2[s*COEF_W +: COEF_W] = rand_gain();
            ra1[s*COEF_W +: COEF_W] = a1[COEF_W-1:0];
            ra2[s*COEF_W +: COEF_W] = a2[COEF_W-1:0];
        end
        write_coef(REG_B0, rb0);
        write_coef(REG_B1, rb1);
        write_coef(REG_B2, rb2);
        write_coef(REG_A1, ra1);
        write_coef(REG_A2, ra2);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients make the cascade a unity pass-through.
    task automatic test_passthrough();
        push_sample('0);
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        push_sample(16'sh0080);
        drain_results();
    endtask

    // Coefficient extremes drive every section into saturation; then the
    // all-zero setting, then writes to indexes past the register list.
    task automatic test_extreme_coefs();
        write_all_coefs({STAGES{COEF_MAX}});
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample('0);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        drain_results();

        write_all_coefs({STAGES{COEF_MIN}});
        push_sample(SMP_MIN);
        push_sample(SMP_MAX);
        push_sample(16'sh0100);
        push_sample('0);
        push_sample(-16'sd256);
        drain_results();

        write_all_coefs('0);
        push_sample(SMP_MAX);
        push_sample(16'sh1234);
        push_sample(SMP_MIN);
        drain_results();

        // back to unity gain; the stray writes below must not land anywhere
        write_all_coefs('0);
        write_coef(REG_B0, B0_RESET);
        for (int k = NUM_REGS; k < (1 << IDX_W); k++) write_coef(k[IDX_W-1:0], '1);
        push_sample(16'sh4321);
        push_sample(SMP_MIN);
        push_sample(16'sh0FFF);
        drain_results();
    endtask

    // Bulk of the run: well-behaved filters with random content. Now and
    // then the source waits for the pipe to empty mid stream.
    task automatic test_stable_filters();
        for (int ph = 0; ph < 10; ph++) begin
            load_stable_filter();
            for (int n = 0; n < 140; n++) begin
                push_sample(rand_sample());
                if ($urandom_range(0, 59) == 0) drain_results();
            end
            drain_results();
        end
    endtask

    // Arbitrary register contents, mostly unstable and heavily clipping.
    task automatic test_random_coefs();
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < NUM_REGS; k++) write_coef(k[IDX_W-1:0], rand_reg());
            for (int n = 0; n < 60; n++) push_sample(rand_sample());
            drain_results();
        end
    endtask

    // No idling on either side: the block sets the pace on its own.
    task automatic test_back_to_back();
        load_stable_filter();
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        for (int n = 0; n < 300; n++) push_sample(rand_sample());
        drain_results();
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the output checker
    // ------------------------------------------------------------------

    // i_ready stalls of random length, with calm windows mixed in
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            if (calm_left != 0) begin
                calm_left--;
            end else if (!sink_calm) begin
                if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(100, 400);
                else if ($urandom_range(0, 5) == 0) stall_left = rand_pause();
            end
        end
    end

    // every taken output word is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (filt_pending.size() == 0) begin
                flag_mismatch($sformatf("output %0d with nothing pending", o_sample_out));
            end else begin
                due = filt_pending.pop_front();
                words_out++;
                if (o_clipped) clips_seen++;
                if (o_sample_out !== due.smp)
                    flag_mismatch($sformatf("word %0d sample_out %0d, want %0d",
                                            due.seq, o_sample_out, due.smp));
                if (o_clipped !== due.clip)
                    flag_mismatch($sformatf("word %0d clipped %b, want %b",
                                            due.seq, o_clipped, due.clip));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("tb_iir_biquad_cascade NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        coef_word[REG_B0] = B0_RESET;
        coef_word[REG_B1] = '0;
        coef_word[REG_B2] = '0;
        coef_word[REG_A1] = '0;
        coef_word[REG_A2] = '0;
        for (int s = 0; s < STAGES; s++) begin
            dly1[s] = '0;
            dly2[s] = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_extreme_coefs();
        test_stable_filters();
        test_random_coefs();
        test_back_to_back();

        drain_results();
        // catch any stray word the block might still emit
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Ran %0d samples over %0d register writes (unity, extreme, zero,",
                 words_in, cfg_writes);
        $display("  stable and random filters): %0d outputs checked, %0d clipped, %0d errors",
                 words_out, clips_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_iir_biquad_cascade OK");
        end else begin
            $display("tb_iir_biquad_cascade NOT OK");
        end
        $finish;
    end

endmodule
